/* hw/rtl/swdc_pkg.sv */
// Shared types and constants of the single-wire duty-cycle frame receiver.
package swdc_pkg;

    localparam int FRAME_W   = 40;
    localparam int TIME_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [FRAME_W-1:0] FRAME_ONES   = '1;
    localparam logic [TIME_W-1:0]  NO_REFERENCE = 8'hff;
    localparam logic [TIME_W-1:0]  SPIKE_LIMIT  = 8'd2;
    localparam logic [TIME_W-1:0]  TOL_RESET    = 8'd3;
    localparam int                 MARK_BIT_A   = 18;
    localparam int                 MARK_BIT_B   = 39;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_EDGE    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIKE_EN  = 1'd0,
        CFG_START_TOL = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [TIME_W-1:0]  ref_time;
        logic [TIME_W-1:0]  low_time;
        logic               listening;
    } state_t;

    typedef struct packed {
        logic              spike_en;
        logic [TIME_W-1:0] start_tol;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic              level;
        logic [TIME_W-1:0] elapsed;
    } req_t;

endpackage

/* hw/rtl/swdc_cfg.sv */
// Configuration register file of the frame receiver.
module swdc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [swdc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [swdc_pkg::CFG_DAT_W-1:0]    wr_data,
    output swdc_pkg::cfg_t                    cfg
);

    swdc_pkg::cfg_t cfg_reg;
    swdc_pkg::cfg_t cfg_next;

    // Decode the register index and merge the write data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (swdc_pkg::cfg_idx_t'(wr_index))
                swdc_pkg::CFG_SPIKE_EN:  cfg_next.spike_en  = wr_data[0];
                swdc_pkg::CFG_START_TOL: cfg_next.start_tol = wr_data[swdc_pkg::TIME_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spike_en  <= 1'b0;
            cfg_reg.start_tol <= swdc_pkg::TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/swdc_step.sv */
// Next-state and result logic for one request of the frame receiver.
module swdc_step (
    input  swdc_pkg::req_t    req,
    input  swdc_pkg::cfg_t    cfg,
    input  swdc_pkg::state_t  cur,
    output swdc_pkg::state_t  nxt,
    output logic              ok
);

    logic                        spike;
    logic [swdc_pkg::TIME_W-1:0] diff;
    logic                        mark_seen;

    // Spike test, start-bit distance and end-of-frame marker
    always_comb
    begin
        spike     = cfg.spike_en && (req.elapsed < swdc_pkg::SPIKE_LIMIT);
        diff      = (cur.low_time > req.elapsed) ? (cur.low_time - req.elapsed)
                                                 : (req.elapsed - cur.low_time);
        mark_seen = !cur.frame[swdc_pkg::MARK_BIT_A] || !cur.frame[swdc_pkg::MARK_BIT_B];
    end

    // Decode the opcode and work out the next state
    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        unique case (req.op)
            swdc_pkg::OP_START:
            begin
                nxt.listening = 1'b1;
                nxt.ref_time  = swdc_pkg::NO_REFERENCE;
                nxt.low_time  = '0;
                nxt.frame     = swdc_pkg::FRAME_ONES;
            end
            swdc_pkg::OP_EDGE:
            begin
                if (cur.listening && !spike)
                begin
                    if (req.level)
                    begin
                        nxt.low_time = req.elapsed;
                        if (cur.ref_time != swdc_pkg::NO_REFERENCE)
                        begin
                            nxt.frame = {cur.frame[swdc_pkg::FRAME_W-2:0],
                                         (req.elapsed < cur.ref_time)};
                        end
                    end
                    else if (diff < cfg.start_tol)
                    begin
                        nxt.ref_time = req.elapsed;
                    end
                end
            end
            swdc_pkg::OP_TIMEOUT:
            begin
                if (cur.listening)
                begin
                    if (mark_seen)
                    begin
                        nxt.listening = 1'b0;
                    end
                    else
                    begin
                        nxt.frame    = swdc_pkg::FRAME_ONES;
                        nxt.low_time = '0;
                    end
                end
            end
            swdc_pkg::OP_STOP:
            begin
                if (cur.listening)
                begin
                    nxt.listening = 1'b0;
                    nxt.frame     = swdc_pkg::FRAME_ONES;
                end
                else
                begin
                    ok = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* hw/rtl/single_wire_duty_cycle_frame_receiver_unit.sv */
// Top level of the single-wire duty-cycle frame receiver.
//
// Requests (opcode, level, elapsed) enter on the input channel: a request is
// taken at a clock edge with in_valid high and in_stall low. Each request gives
// exactly one result (frame, armed, success) on the output channel, taken at an
// edge with out_valid high and out_stall low.
// A request passes the input register, then the result register. Throughput
// is one request per cycle while out_stall is low; the input register keeps
// taking requests while the result is being taken, since both registers
// advance together whenever the result register is empty or being drained.
// When the receiver stalls, the result holds; one more request is absorbed in
// the input register and in_stall then rises until the result is taken.
// Configuration writes (index 0 spike filter enable, index 1 start tolerance)
// are always ready and apply to requests that reach the result stage later.
// Reset clears both stages, disarms the receiver, fills the frame with ones,
// sets the reference time to 255, the low time to 0, the spike filter off and
// the start tolerance to 3.
module single_wire_duty_cycle_frame_receiver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic                            level,
    input  logic [swdc_pkg::TIME_W-1:0]     elapsed,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swdc_pkg::FRAME_W-1:0]    frame,
    output logic                            armed,
    output logic                            success,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swdc_pkg::CFG_DAT_W-1:0]  cfg_data
);

    swdc_pkg::cfg_t   cfg;
    swdc_pkg::req_t   req_reg;
    swdc_pkg::state_t st_reg;
    swdc_pkg::state_t st_next;
    logic             in_vld_reg;
    logic             out_vld_reg;
    logic [swdc_pkg::FRAME_W-1:0] frame_reg;
    logic             armed_reg;
    logic             success_reg;
    logic             ok;
    logic             out_free;
    logic             load_out;

    // Configuration registers
    assign cfg_ready = 1'b1;

    swdc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance control: result stage frees up when empty or drained
    assign out_free = !out_vld_reg || !out_stall;
    assign load_out = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg.op      <= swdc_pkg::op_t'(opcode);
            req_reg.level   <= level;
            req_reg.elapsed <= elapsed;
        end
    end

    // Next state for the request in the input register
    swdc_step u_step (
        .req (req_reg),
        .cfg (cfg),
        .cur (st_reg),
        .nxt (st_next),
        .ok  (ok)
    );

    // Receiver state, updated as each request moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.frame     <= swdc_pkg::FRAME_ONES;
            st_reg.ref_time  <= swdc_pkg::NO_REFERENCE;
            st_reg.low_time  <= '0;
            st_reg.listening <= 1'b0;
        end
        else if (load_out)
        begin
            st_reg <= st_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            frame_reg   <= st_next.frame;
            armed_reg   <= st_next.listening;
            success_reg <= ok;
        end
    end

    assign out_valid = out_vld_reg;
    assign frame     = frame_reg;
    assign armed     = armed_reg;
    assign success   = success_reg;

    // A stop request always leaves the receiver disarmed
    a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (req_reg.op == swdc_pkg::OP_STOP) |=> !armed)
        else $error("stop request left the receiver armed");

    // Success is only reported with a disarmed receiver
    a_success_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> !armed)
        else $error("success reported while armed");

    // The published armed flag follows the internal state
    a_armed_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (armed == st_reg.listening) && (frame == st_reg.frame))
        else $error("result does not match receiver state");

    // Input side only stalls with a request held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg)
        else $error("input stalled with nothing held");

endmodule
